@@ rtl/rational_arithmetic_unit_macros.svh @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_macros
// assertion macros for the rational arithmetic unit datapath (rau_dp)
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// implication checked on every clock outside reset
`define RAU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition that must never hold outside reset
`define RAU_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ rtl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg
// types and codes shared by the rational arithmetic unit controller and datapath
// ----------------------------------------------------------------------------
package rau_pkg;

  // operation codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;
  localparam logic [2:0] OP_RED = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // compare codes
  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  // datapath micro-operations
  typedef enum logic [4:0] {
    MOP_NONE,
    MOP_LOAD,
    MOP_XY_A,
    MOP_XY_B,
    MOP_XY_DEN,
    MOP_GCD,
    MOP_DIVX,
    MOP_DIVY,
    MOP_A_SET,
    MOP_B_SET,
    MOP_MUL_TA,
    MOP_MUL_TB,
    MOP_MUL_DEN,
    MOP_ADD,
    MOP_MUL_NUM,
    MOP_MUL_DD,
    MOP_CMP_TA,
    MOP_CMP_TB,
    MOP_CMP,
    MOP_FIN,
    MOP_PUBLISH
  } mop_t;

  typedef struct packed {
    mop_t mop;
  } cmd_t;

  typedef struct packed {
    logic       special;   // result already settled at load
    logic       busy;      // gcd or divider running
    logic       out_full;  // output register holds an untaken result
    logic [2:0] op;
  } stat_t;

endpackage

@@ rtl/rational_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// add, subtract, multiply, divide, compare and reduce of signed fractions
// ----------------------------------------------------------------------------
// One transaction at a time: an item takes longest for add or subtract with
// large coprime operands and least for reduce, plus any time the previous
// result still waits in the output register. The time is set by the shared
// binary gcd unit (one step per cycle) and the restoring divider (two
// quotients per normalise). Reduce normalises a once, compare normalises both
// operands, multiply and divide add a normalise of the product, and add and
// subtract also form the lcm of the denominators, four gcd runs in all. A new
// input is taken as soon as the previous result sits in the output register,
// even while it waits to be taken. Results are fully reduced with a positive
// denominator; a zero denominator gives status 1 and 0/1, a result outside
// WIDTH bits gives status 2 and 0/1.
module rational_arithmetic_unit #(
  parameter int WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // a_num, a_den, b_num, b_den
  input  logic [2:0]   s_tuser,   // operation
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata,   // res_num, res_den, order, zero fill
  output logic [1:0]   m_tuser    // status
);
  import rau_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic [1:0]  order;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rau_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (s_tuser),
    .in_a_num   (s_tdata[31:0]),
    .in_a_den   (s_tdata[63:32]),
    .in_b_num   (s_tdata[95:64]),
    .in_b_den   (s_tdata[127:96]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_num    (res_num),
    .out_den    (res_den),
    .out_order  (order),
    .out_status (m_tuser)
  );

  assign m_tdata = {7'd0, order, res_den, res_num};

endmodule

@@ rtl/rau_ctrl.sv @@
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer that steps the datapath through normalise, combine and check
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_ready,
  input  rau_pkg::stat_t stat,
  output rau_pkg::cmd_t  cmd
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WAIT = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t     state, state_next;
  logic [4:0] pc, pc_next;
  logic [4:0] step_next;
  mop_t       step_mop;
  logic       go_wait;
  logic       go_done;

  // microprogram
  always_comb begin
    step_mop  = MOP_NONE;
    step_next = pc + 5'd1;
    go_wait   = 1'b0;
    go_done   = 1'b0;
    unique case (pc)
      5'd0: begin
        if (stat.special) go_done = 1'b1;
        else step_mop = MOP_XY_A;
      end
      5'd1, 5'd6, 5'd11, 5'd21: begin
        step_mop = MOP_GCD;
        go_wait  = 1'b1;
      end
      5'd2, 5'd7, 5'd12, 5'd22: begin
        step_mop = MOP_DIVX;
        go_wait  = 1'b1;
      end
      5'd3, 5'd8, 5'd13, 5'd23: begin
        step_mop = MOP_DIVY;
        go_wait  = 1'b1;
      end
      5'd4: begin
        step_mop = MOP_A_SET;
        if (stat.op == OP_RED) step_next = 5'd24;
      end
      5'd5: step_mop = MOP_XY_B;
      5'd9: begin
        step_mop = MOP_B_SET;
        priority if (stat.op == OP_CMP) step_next = 5'd25;
        else if (stat.op == OP_MUL || stat.op == OP_DIV) step_next = 5'd18;
        else step_next = 5'd10;
      end
      5'd10: step_mop = MOP_XY_DEN;
      5'd14: step_mop = MOP_MUL_TA;
      5'd15: step_mop = MOP_MUL_TB;
      5'd16: step_mop = MOP_MUL_DEN;
      5'd17: begin
        step_mop  = MOP_ADD;
        step_next = 5'd21;
      end
      5'd18: step_mop = MOP_MUL_NUM;
      5'd19: begin
        step_mop  = MOP_MUL_DD;
        step_next = 5'd21;
      end
      5'd24: begin
        step_mop = MOP_FIN;
        go_done  = 1'b1;
      end
      5'd25: step_mop = MOP_CMP_TA;
      5'd26: step_mop = MOP_CMP_TB;
      5'd27: begin
        step_mop = MOP_CMP;
        go_done  = 1'b1;
      end
      default: go_done = 1'b1;
    endcase
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    cmd.mop    = MOP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.mop    = MOP_LOAD;
          pc_next    = 5'd0;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.mop = step_mop;
        pc_next = step_next;
        priority if (go_done) state_next = S_DONE;
        else if (go_wait) state_next = S_WAIT;
        else state_next = S_RUN;
      end
      S_WAIT: begin
        if (!stat.busy) state_next = S_RUN;
      end
      S_DONE: begin
        if (!stat.out_full || out_ready) begin
          cmd.mop    = MOP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= 5'd0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

@@ rtl/rau_dp.sv @@
// ----------------------------------------------------------------------------
// rau_dp
// operand registers, shared multiplier, binary gcd unit, bit-serial divider
// and output register of the rational arithmetic unit
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_macros.svh"

module rau_dp #(
  parameter int WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  rau_pkg::cmd_t  cmd,
  output rau_pkg::stat_t stat,
  input  logic [2:0]     in_op,
  input  logic [31:0]    in_a_num,
  input  logic [31:0]    in_a_den,
  input  logic [31:0]    in_b_num,
  input  logic [31:0]    in_b_den,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_num,
  output logic [30:0]    out_den,
  output logic [1:0]     out_order,
  output logic [1:0]     out_status
);
  import rau_pkg::*;

  localparam logic [63:0] LIM    = 64'd1 << (WIDTH - 1);
  localparam logic [63:0] LIM_M1 = LIM - 64'd1;

  logic [2:0]  op_r;
  logic        special;
  logic [31:0] an, ad, bn, bd;
  logic        a_neg, b_neg, r_neg;
  logic [63:0] x, y, t1, t2, g;

  // gcd unit
  logic [63:0] gx, gy;
  logic [5:0]  gk;
  logic        gcd_busy;

  // divider
  logic [63:0] dq, rem;
  logic [5:0]  div_cnt;
  logic        div_busy, div_to_y;
  logic [64:0] trial;
  logic        trial_ge;
  logic [63:0] rem_step, dq_step;

  // result before the output register
  logic [31:0] r_num;
  logic [30:0] r_den;
  logic [1:0]  r_ord, r_st;

  // multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  // load decode
  logic [31:0] an_mag, ad_mag, bn_mag, bd_mag;
  logic        ld_unused, ld_zero;

  // finish and compare
  logic               fin_neg, fin_ovf;
  logic signed [64:0] cl, cr;

  always_comb begin
    mul_a = an;
    mul_b = y[31:0];
    unique case (cmd.mop)
      MOP_MUL_TB:  begin mul_a = bn; mul_b = x[31:0]; end
      MOP_MUL_DEN: begin mul_a = ad; mul_b = y[31:0]; end
      MOP_MUL_NUM: begin mul_a = an; mul_b = bn;      end
      MOP_MUL_DD:  begin mul_a = ad; mul_b = bd;      end
      MOP_CMP_TA:  begin mul_a = an; mul_b = bd;      end
      MOP_CMP_TB:  begin mul_a = bn; mul_b = ad;      end
      default:     begin mul_a = an; mul_b = y[31:0]; end
    endcase
  end
  assign prod = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    an_mag    = in_a_num[31] ? (32'd0 - in_a_num) : in_a_num;
    ad_mag    = in_a_den[31] ? (32'd0 - in_a_den) : in_a_den;
    bn_mag    = in_b_num[31] ? (32'd0 - in_b_num) : in_b_num;
    bd_mag    = in_b_den[31] ? (32'd0 - in_b_den) : in_b_den;
    ld_unused = (in_op > OP_RED);
    ld_zero   = (in_a_den == 32'd0) ||
                (in_op != OP_RED && in_b_den == 32'd0) ||
                (in_op == OP_DIV && in_b_num == 32'd0);
  end

  always_comb begin
    trial    = {rem, dq[63]};
    trial_ge = (trial >= {1'b0, g});
    rem_step = trial_ge ? 64'(trial - {1'b0, g}) : trial[63:0];
    dq_step  = {dq[62:0], trial_ge};
  end

  always_comb begin
    fin_neg = r_neg && (x != 64'd0);
    fin_ovf = (y > LIM_M1) || (fin_neg ? (x > LIM) : (x > LIM_M1));
    cl      = a_neg ? (65'sd0 - $signed({1'b0, t1})) : $signed({1'b0, t1});
    cr      = b_neg ? (65'sd0 - $signed({1'b0, t2})) : $signed({1'b0, t2});
  end

  // operand and working registers
  always_ff @(posedge clk) begin
    unique case (cmd.mop)
      MOP_LOAD: begin
        op_r  <= in_op;
        an    <= an_mag;
        ad    <= ad_mag;
        bn    <= bn_mag;
        bd    <= bd_mag;
        a_neg <= in_a_num[31] ^ in_a_den[31];
        b_neg <= in_b_num[31] ^ in_b_den[31];
        r_num <= 32'd0;
        r_den <= 31'd1;
        r_ord <= ORD_LT;
        r_st  <= ld_unused ? ST_OK : (ld_zero ? ST_ZERO_DEN : ST_OK);
      end
      MOP_XY_A: begin
        x <= 64'(an);
        y <= 64'(ad);
      end
      MOP_XY_B: begin
        x <= 64'(bn);
        y <= 64'(bd);
      end
      MOP_XY_DEN: begin
        x <= 64'(ad);
        y <= 64'(bd);
      end
      MOP_A_SET: begin
        an    <= x[31:0];
        ad    <= y[31:0];
        r_neg <= a_neg;
      end
      MOP_B_SET: begin
        // reciprocal of a reduced fraction is a plain swap
        if (op_r == OP_DIV) begin
          bn <= y[31:0];
          bd <= x[31:0];
        end else begin
          bn <= x[31:0];
          bd <= y[31:0];
        end
        if (op_r == OP_SUB) b_neg <= !b_neg;
      end
      MOP_MUL_TA, MOP_CMP_TA: t1 <= prod;
      MOP_MUL_TB, MOP_CMP_TB: t2 <= prod;
      MOP_MUL_DEN: y <= prod;
      MOP_MUL_NUM: x <= prod;
      MOP_MUL_DD: begin
        y     <= prod;
        r_neg <= a_neg ^ b_neg;
      end
      MOP_ADD: begin
        priority if (a_neg == b_neg) begin
          x     <= t1 + t2;
          r_neg <= a_neg;
        end else if (t1 >= t2) begin
          x     <= t1 - t2;
          r_neg <= a_neg;
        end else begin
          x     <= t2 - t1;
          r_neg <= b_neg;
        end
      end
      MOP_CMP: begin
        priority if (cl < cr) r_ord <= ORD_LT;
        else if (cl > cr) r_ord <= ORD_GT;
        else r_ord <= ORD_EQ;
        r_num <= 32'd0;
        r_den <= 31'd1;
        r_st  <= ST_OK;
      end
      MOP_FIN: begin
        r_ord <= ORD_LT;
        if (fin_ovf) begin
          r_num <= 32'd0;
          r_den <= 31'd1;
          r_st  <= ST_OVERFLOW;
        end else begin
          r_num <= fin_neg ? (32'd0 - x[31:0]) : x[31:0];
          r_den <= y[30:0];
          r_st  <= ST_OK;
        end
      end
      default: begin
        if (div_busy && div_cnt == 6'd63) begin
          if (div_to_y) y <= dq_step;
          else x <= dq_step;
        end
      end
    endcase
  end

  // special result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      special <= 1'b0;
    end else if (cmd.mop == MOP_LOAD) begin
      special <= ld_unused || ld_zero;
    end
  end

  // binary gcd, one step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      gcd_busy <= 1'b0;
    end else if (cmd.mop == MOP_GCD) begin
      gx       <= x;
      gy       <= y;
      gk       <= 6'd0;
      gcd_busy <= 1'b1;
    end else if (gcd_busy) begin
      priority if (gx == 64'd0) begin
        g        <= gy << gk;
        gcd_busy <= 1'b0;
      end else if (gy == 64'd0) begin
        g        <= gx << gk;
        gcd_busy <= 1'b0;
      end else if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1;
        gy <= gy >> 1;
        gk <= gk + 6'd1;
      end else if (!gx[0]) begin
        gx <= gx >> 1;
      end else if (!gy[0]) begin
        gy <= gy >> 1;
      end else if (gx >= gy) begin
        gx <= gx - gy;
      end else begin
        gy <= gy - gx;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.mop == MOP_DIVX || cmd.mop == MOP_DIVY) begin
      dq       <= (cmd.mop == MOP_DIVY) ? y : x;
      rem      <= 64'd0;
      div_cnt  <= 6'd0;
      div_to_y <= (cmd.mop == MOP_DIVY);
      div_busy <= 1'b1;
    end else if (div_busy) begin
      dq      <= dq_step;
      rem     <= rem_step;
      div_cnt <= div_cnt + 6'd1;
      if (div_cnt == 6'd63) div_busy <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.mop == MOP_PUBLISH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mop == MOP_PUBLISH) begin
      out_num    <= r_num;
      out_den    <= r_den;
      out_order  <= r_ord;
      out_status <= r_st;
    end
  end

  assign stat.special  = special;
  assign stat.busy     = gcd_busy || div_busy;
  assign stat.out_full = out_valid;
  assign stat.op       = op_r;

  `RAU_ASSERT_NEVER(a_units_excl, gcd_busy && div_busy, "gcd unit and divider busy together")
  `RAU_ASSERT_IMP(a_div_nonzero, div_busy, g != 64'd0, "divider running on a zero gcd")
  `RAU_ASSERT_IMP(a_publish_free, cmd.mop == MOP_PUBLISH, !out_valid || out_ready, "result overwritten")
  `RAU_ASSERT_IMP(a_den_pos, out_valid, out_den != 31'd0, "zero denominator delivered")

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the rational arithmetic unit: directed and random
// fraction pairs over all operations, checked against an in-bench predictor
// ----------------------------------------------------------------------------
module testbench;
  import rau_pkg::*;

  localparam int W = 32;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] an;
    logic [31:0] ad;
    logic [31:0] bn;
    logic [31:0] bd;
  } item_t;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  ord;
    logic [1:0]  st;
  } res_t;

  typedef struct {
    logic        neg;
    logic [63:0] mag;
    logic [63:0] den;
  } frac_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [71:0]  m_tdata;
  logic [1:0]   m_tuser;

  item_t pending_items[$];
  res_t  expected_results[$];
  int    errors;
  int    sent;
  int    received;
  int    idle_cycles;
  int    send_gap;
  int    recv_gap;
  int    op_count[8];
  logic  stim_done;
  logic  s_tready_seen;
  logic  m_taken_seen;
  logic  recv_drawn;

  rational_arithmetic_unit #(.WIDTH(W)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_t reduce_frac(logic neg, logic [63:0] mag, logic [63:0] den);
    frac_t f;
    logic [63:0] g;
    g = gcd64(mag, den);
    f.mag = mag / g;
    f.den = den / g;
    f.neg = (f.mag != 0) && neg;
    return f;
  endfunction

  function automatic frac_t to_frac(logic [31:0] n, logic [31:0] d);
    logic [63:0] nm;
    logic [63:0] dm;
    nm = n[31] ? 64'h1_0000_0000 - {32'd0, n} : {32'd0, n};
    dm = d[31] ? 64'h1_0000_0000 - {32'd0, d} : {32'd0, d};
    return reduce_frac(n[31] != d[31], nm, dm);
  endfunction

  function automatic res_t make_res(logic [31:0] n, logic [30:0] d, logic [1:0] o,
                                    logic [1:0] s);
    res_t r;
    r.num = n;
    r.den = d;
    r.ord = o;
    r.st = s;
    return r;
  endfunction

  function automatic res_t predict_fraction(item_t it);
    frac_t a;
    frac_t b;
    frac_t r;
    logic [63:0] g;
    logic [63:0] ta;
    logic [63:0] tb;
    logic [63:0] lim;
    longint left;
    longint right;
    lim = 64'd1 << (W - 1);
    if (it.op > OP_RED) return make_res(32'd0, 31'd1, ORD_LT, ST_OK);
    if (it.ad == 0 || (it.op != OP_RED && it.bd == 0) || (it.op == OP_DIV && it.bn == 0))
      return make_res(32'd0, 31'd1, ORD_LT, ST_ZERO_DEN);
    a = to_frac(it.an, it.ad);
    if (it.op == OP_RED) begin
      r = a;
    end else begin
      b = to_frac(it.bn, it.bd);
      if (it.op == OP_CMP) begin
        left = (a.neg ? -longint'(a.mag) : longint'(a.mag)) * longint'(b.den);
        right = (b.neg ? -longint'(b.mag) : longint'(b.mag)) * longint'(a.den);
        return make_res(32'd0, 31'd1,
                        left < right ? ORD_LT : (left > right ? ORD_GT : ORD_EQ), ST_OK);
      end
      if (it.op == OP_SUB) b.neg = (b.mag != 0) && !b.neg;
      if (it.op == OP_DIV) b = reduce_frac(b.neg, b.den, b.mag);
      if (it.op == OP_ADD || it.op == OP_SUB) begin
        g = gcd64(a.den, b.den);
        ta = a.mag * (b.den / g);
        tb = b.mag * (a.den / g);
        if (a.neg == b.neg) r = reduce_frac(a.neg, ta + tb, a.den * (b.den / g));
        else if (ta >= tb) r = reduce_frac(a.neg, ta - tb, a.den * (b.den / g));
        else r = reduce_frac(b.neg, tb - ta, a.den * (b.den / g));
      end else begin
        r = reduce_frac(a.neg != b.neg, a.mag * b.mag, a.den * b.den);
      end
    end
    if (r.den > lim - 1 || (r.neg ? r.mag > lim : r.mag > lim - 1))
      return make_res(32'd0, 31'd1, ORD_LT, ST_OVERFLOW);
    return make_res(r.neg ? 32'(64'd0 - r.mag) : r.mag[31:0], r.den[30:0], ORD_LT, ST_OK);
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 40);
      2: v = -$urandom_range(0, 40);
      3: v = $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff - $urandom_range(0, 3);
      4: v = $urandom_range(1, 6) * (32'd1 << $urandom_range(0, 26));
      default: v = $urandom_range(0, 1) ? $urandom_range(0, 65535) : -$urandom_range(0, 65535);
    endcase
    if ($urandom_range(0, 30) == 0) v = 0;
    return v;
  endfunction

  task automatic queue_item(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                            logic [31:0] bn, logic [31:0] bd);
    item_t it;
    it.op = op;
    it.an = an;
    it.ad = ad;
    it.bn = bn;
    it.bd = bd;
    pending_items.push_back(it);
  endtask

  initial begin
    errors = 0;
    stim_done = 1'b0;
    rst = 1'b1;
    // directed: every operation, zero denominators, overflow, extremes, unused codes
    for (int op = 0; op < 6; op++) queue_item(3'(op), 6, -4, -10, 15);
    queue_item(OP_ADD, 1, 0, 1, 2);
    queue_item(OP_MUL, 1, 2, 1, 0);
    queue_item(OP_DIV, 1, 2, 0, 5);
    queue_item(OP_RED, 7, 14, 0, 0);
    queue_item(OP_RED, 32'h8000_0000, -1, 0, 0);
    queue_item(OP_RED, 32'h8000_0000, 1, 0, 0);
    queue_item(OP_ADD, 32'h7fff_ffff, 1, 1, 1);
    queue_item(OP_SUB, 32'h8000_0000, 1, 1, 1);
    queue_item(OP_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_fffd);
    queue_item(OP_DIV, 1, 32'h7fff_ffff, 32'h7fff_fffe, 1);
    queue_item(OP_ADD, 1, 32'h7fff_ffff, 1, 32'h7fff_fffe);
    queue_item(OP_CMP, 32'h8000_0000, 1, 32'h7fff_ffff, 32'h8000_0000);
    queue_item(OP_CMP, 3, 6, -1, -2);
    queue_item(OP_SUB, 5, 7, 5, 7);
    queue_item(OP_MUL, 0, -9, 5, 3);
    queue_item(3'd6, 1, 2, 3, 4);
    queue_item(3'd7, 32'hffff_ffff, 0, 32'hffff_ffff, 0);
    queue_item(OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    for (int i = 0; i < 950; i++)
      queue_item(3'($urandom_range(0, 20) == 0 ? $urandom_range(6, 7) : $urandom_range(0, 5)),
                 rand_word(), rand_word(), rand_word(), rand_word());
    stim_done = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
      send_gap <= $urandom_range(0, 3);
    end else if (!s_tvalid || s_tready_seen) begin
      if (send_gap > 0 || pending_items.size() == 0) begin
        s_tvalid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        s_tvalid <= 1'b1;
        s_tuser <= pending_items[0].op;
        s_tdata <= {pending_items[0].bd, pending_items[0].bn,
                    pending_items[0].ad, pending_items[0].an};
        void'(pending_items.pop_front());
        send_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : 0;
      end
    end
  end

  // handshakes seen at the last rising edge
  always @(posedge clk) begin
    s_tready_seen <= s_tvalid && s_tready;
    m_taken_seen <= m_tvalid && m_tready;
  end

  // receiver stall, drawn once for every result as it shows up
  always @(negedge clk) begin
    int draw;
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap <= 0;
      recv_drawn <= 1'b0;
    end else if (m_taken_seen) begin
      m_tready <= 1'b0;
      recv_drawn <= 1'b0;
    end else if (m_tvalid && !recv_drawn) begin
      draw = $urandom_range(0, 3);
      m_tready <= (draw == 0);
      recv_gap <= draw;
      recv_drawn <= 1'b1;
    end else if (recv_gap > 0) begin
      m_tready <= (recv_gap == 1);
      recv_gap <= recv_gap - 1;
    end
  end

  // monitor: predict on input transaction, check on output transaction
  always @(posedge clk) begin
    item_t it;
    res_t got;
    res_t want;
    if (rst) begin
      idle_cycles <= 0;
      sent <= 0;
      received <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        it.op = s_tuser;
        it.an = s_tdata[31:0];
        it.ad = s_tdata[63:32];
        it.bn = s_tdata[95:64];
        it.bd = s_tdata[127:96];
        expected_results.push_back(predict_fraction(it));
        op_count[it.op]++;
        sent <= sent + 1;
      end
      if (m_tvalid && m_tready) begin
        got = make_res(m_tdata[31:0], m_tdata[62:32], m_tdata[64:63], m_tuser);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result num=%0d den=%0d ord=%0d st=%0d", $time,
                   $signed(got.num), got.den, got.ord, got.st);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected num=%0d den=%0d ord=%0d st=%0d", $time,
                     $signed(want.num), want.den, want.ord, want.st);
            $display("%0t:          actual   num=%0d den=%0d ord=%0d st=%0d", $time,
                     $signed(got.num), got.den, got.ord, got.st);
            errors++;
          end
        end
        received <= received + 1;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) op_count[i] = 0;
    wait (stim_done && !rst);
    while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0) begin
      @(posedge clk);
      if (idle_cycles >= WATCHDOG) begin
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("TEST FAILED");
        $finish;
      end
    end
    repeat (1000) @(posedge clk);
    $display("%0d fraction transactions sent, %0d results checked", sent, received);
    $display("per op: add %0d sub %0d mul %0d div %0d cmp %0d red %0d unused %0d",
             op_count[0], op_count[1], op_count[2], op_count[3], op_count[4], op_count[5],
             op_count[6] + op_count[7]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/rau_pkg.sv
rtl/rau_ctrl.sv
rtl/rau_dp.sv
rtl/rational_arithmetic_unit.sv
bench/testbench.sv
